### design/dck_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dck_pkg;

   localparam int CFG_W         = 8;
   localparam int NODE_FIELD_W  = 7;
   localparam int DEF_MAX_NODES = 128;
   localparam int DEF_MAX_EDGES = 128;

   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 8'd128;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_RUN = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [NODE_FIELD_W-1:0] src_node;
      logic [NODE_FIELD_W-1:0] dst_node;
   } req_type;

   typedef struct packed {
      logic             is_acyclic;
      logic [CFG_W-1:0] ordered_count;
      logic             edges_dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_SCAN_END,
      ST_POP,
      ST_POP_WAIT,
      ST_HEAD_WAIT,
      ST_EDGE,
      ST_EDGE_WAIT,
      ST_DEG_WAIT,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

### design/dag_cycle_check_kahn.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  ports                              moves
// req      in   req_valid req_ready req_data       add-edge or run word
// rsp      out  rsp_valid rsp_ready rsp_data       one word per run
// csr      in   csr_wr_en csr_wr_data              node_count register
//
// add: read-modify-write of list head and in-degree through rams with one read
//   port and one write port; a dropped edge only sets the dropped flag
// run: scan of the n active nodes, then per ordered node a pop, head read and
//   edge walk, then emit and a clearing pass over MAX_NODES entries; n = active nodes
// reset: clearing pass over all MAX_NODES entries before the first word is taken
// a finished run waits in the emit step while rsp is stalled; no req word is taken then
module dag_cycle_check_kahn #(
   parameter int MAX_NODES = dck_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = dck_pkg::DEF_MAX_EDGES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire dck_pkg::req_type         req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output dck_pkg::rsp_type              rsp_data,
   input  wire logic                     csr_wr_en,
   input  wire logic [dck_pkg::CFG_W-1:0] csr_wr_data
);

   import dck_pkg::*;

   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int CNT_W      = $clog2(MAX_NODES + 1);
   localparam int EDGE_W     = $clog2(MAX_EDGES + 1);
   localparam int EA_W       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NC_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int EDGE_RAM_W = NODE_FIELD_W + EDGE_W;

   localparam logic [EDGE_W-1:0] EDGE_EMPTY = EDGE_W'(MAX_EDGES);
   localparam logic [NODE_W-1:0] NODE_LAST  = NODE_W'(MAX_NODES - 1);
   localparam logic [CNT_W-1:0]  NODE_FULL  = CNT_W'(MAX_NODES);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]        node_count_ff;
   logic [NODE_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        tail_ff, tail_in;
   logic [EDGE_W-1:0]       edges_ff, edges_in;
   logic                    drop_ff, drop_in;
   logic [NODE_FIELD_W-1:0] src_ff, src_in;
   logic [NODE_FIELD_W-1:0] dst_ff, dst_in;
   logic [EDGE_W-1:0]       e_ff, e_in;
   logic                    scan_chk_ff, scan_chk_in;
   logic [NODE_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                  edge_we, edge_re;
   logic [EA_W-1:0]       edge_waddr, edge_raddr;
   logic [EDGE_RAM_W-1:0] edge_wdata, edge_rd;
   logic                  head_we, head_re;
   logic [NODE_W-1:0]     head_waddr, head_raddr;
   logic [EDGE_W-1:0]     head_wdata, head_rd;
   logic                  deg_we, deg_re;
   logic [NODE_W-1:0]     deg_waddr, deg_raddr;
   logic [EDGE_W-1:0]     deg_wdata, deg_rd;
   logic                  fifo_we, fifo_re;
   logic [NODE_W-1:0]     fifo_waddr, fifo_raddr;
   logic [NODE_W-1:0]     fifo_wdata, fifo_rd;

   logic [NC_W-1:0]         nc_ext;
   logic [CNT_W-1:0]        n_w;
   logic                    add_drop;
   logic                    req_fire;
   logic [NODE_FIELD_W-1:0] edge_tgt;
   logic [EDGE_W-1:0]       edge_link;
   logic                    tgt_ok;
   logic                    emit_go;
   logic [NC_W-1:0]         ordered_ext;

   assign nc_ext    = NC_W'(node_count_ff);
   assign n_w       = (nc_ext > NC_W'(MAX_NODES)) ? NODE_FULL : CNT_W'(nc_ext);
   assign add_drop  = (edges_ff == EDGE_EMPTY)
                      || (NC_W'(req_data.src_node) >= NC_W'(n_w))
                      || (NC_W'(req_data.dst_node) >= NC_W'(n_w));
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign edge_tgt  = edge_rd[EDGE_RAM_W-1:EDGE_W];
   assign edge_link = edge_rd[EDGE_W-1:0];
   assign tgt_ok    = NC_W'(edge_tgt) < NC_W'(n_w);
   assign emit_go   = !rsp_valid_ff || rsp_ready;
   assign ordered_ext = NC_W'(head_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   dck_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_RAM_W)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_en   (edge_re),
      .rd_addr (edge_raddr),
      .rd_data (edge_rd)
   );

   dck_ram #(.DEPTH(MAX_NODES), .WIDTH(EDGE_W)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_en   (head_re),
      .rd_addr (head_raddr),
      .rd_data (head_rd)
   );

   dck_ram #(.DEPTH(MAX_NODES), .WIDTH(EDGE_W)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_waddr),
      .wr_data (deg_wdata),
      .rd_en   (deg_re),
      .rd_addr (deg_raddr),
      .rd_data (deg_rd)
   );

   dck_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_en   (fifo_re),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == NODE_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.op == OP_RUN) begin
                  state_in = (n_w == '0) ? ST_POP : ST_SCAN;
               end else if (!add_drop) begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: state_in = ST_IDLE;
         ST_SCAN: begin
            if (CNT_W'(cnt_ff) == n_w - CNT_W'(1)) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_POP;
         ST_POP: state_in = (head_ff == tail_ff) ? ST_EMIT : ST_POP_WAIT;
         ST_POP_WAIT: state_in = ST_HEAD_WAIT;
         ST_HEAD_WAIT: state_in = ST_EDGE;
         ST_EDGE: state_in = (e_ff < edges_ff) ? ST_EDGE_WAIT : ST_POP;
         ST_EDGE_WAIT: state_in = tgt_ok ? ST_DEG_WAIT : ST_EDGE;
         ST_DEG_WAIT: state_in = ST_EDGE;
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      edges_in     = edges_ff;
      drop_in      = drop_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      e_in         = e_ff;
      scan_chk_in  = 1'b0;
      scan_idx_in  = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      edge_we    = 1'b0;
      edge_waddr = edges_ff[EA_W-1:0];
      edge_wdata = {dst_ff, head_rd};
      edge_re    = 1'b0;
      edge_raddr = e_ff[EA_W-1:0];
      head_we    = 1'b0;
      head_waddr = NODE_W'(src_ff);
      head_wdata = edges_ff;
      head_re    = 1'b0;
      head_raddr = NODE_W'(req_data.src_node);
      deg_we     = 1'b0;
      deg_waddr  = NODE_W'(dst_ff);
      deg_wdata  = deg_rd + EDGE_W'(1);
      deg_re     = 1'b0;
      deg_raddr  = NODE_W'(req_data.dst_node);
      fifo_we    = 1'b0;
      fifo_waddr = tail_ff[NODE_W-1:0];
      fifo_wdata = scan_idx_ff;
      fifo_re    = 1'b0;
      fifo_raddr = head_ff[NODE_W-1:0];

      // zero in-degree nodes found by the scan, in the cycle after the read
      if (scan_chk_ff && deg_rd == '0 && tail_ff < NODE_FULL) begin
         fifo_we = 1'b1;
         tail_in = tail_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = cnt_ff;
            head_wdata = EDGE_EMPTY;
            deg_we     = 1'b1;
            deg_waddr  = cnt_ff;
            deg_wdata  = '0;
            edges_in   = '0;
            drop_in    = 1'b0;
            cnt_in     = (cnt_ff == NODE_LAST) ? '0 : cnt_ff + NODE_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.op == OP_RUN) begin
                  cnt_in  = '0;
                  head_in = '0;
                  tail_in = '0;
               end else if (add_drop) begin
                  drop_in = 1'b1;
               end else begin
                  src_in  = req_data.src_node;
                  dst_in  = req_data.dst_node;
                  head_re = 1'b1;
                  deg_re  = 1'b1;
               end
            end
         end
         ST_ADD: begin
            edge_we  = 1'b1;
            head_we  = 1'b1;
            deg_we   = 1'b1;
            edges_in = edges_ff + EDGE_W'(1);
         end
         ST_SCAN: begin
            deg_re      = 1'b1;
            deg_raddr   = cnt_ff;
            scan_chk_in = 1'b1;
            scan_idx_in = cnt_ff;
            cnt_in      = cnt_ff + NODE_W'(1);
         end
         ST_SCAN_END: begin
         end
         ST_POP: begin
            if (head_ff != tail_ff) begin
               fifo_re = 1'b1;
               head_in = head_ff + CNT_W'(1);
            end
         end
         ST_POP_WAIT: begin
            head_re    = 1'b1;
            head_raddr = fifo_rd;
         end
         ST_HEAD_WAIT: begin
            e_in = head_rd;
         end
         ST_EDGE: begin
            if (e_ff < edges_ff) begin
               edge_re = 1'b1;
            end
         end
         ST_EDGE_WAIT: begin
            e_in = edge_link;
            if (tgt_ok) begin
               deg_re    = 1'b1;
               deg_raddr = NODE_W'(edge_tgt);
            end
         end
         ST_DEG_WAIT: begin
            if (deg_rd != '0) begin
               deg_we    = 1'b1;
               deg_waddr = NODE_W'(edge_tgt);
               deg_wdata = deg_rd - EDGE_W'(1);
               if (deg_rd == EDGE_W'(1) && tail_ff < NODE_FULL) begin
                  fifo_we    = 1'b1;
                  fifo_wdata = NODE_W'(edge_tgt);
                  tail_in    = tail_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            cnt_in = '0;
            if (emit_go) begin
               rsp_valid_in          = 1'b1;
               rsp_in.is_acyclic     = (head_ff == n_w);
               rsp_in.ordered_count  = ordered_ext[CFG_W-1:0];
               rsp_in.edges_dropped  = drop_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_count_ff <= NODE_COUNT_RESET;
         cnt_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         edges_ff      <= '0;
         drop_ff       <= 1'b0;
         scan_chk_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         edges_ff     <= edges_in;
         drop_ff      <= drop_in;
         scan_chk_ff  <= scan_chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      e_ff        <= e_in;
      scan_idx_ff <= scan_idx_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTHESIS
   a_fifo_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("ready queue read past its write pointer");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> (tail_ff <= n_w))
      else $error("more nodes queued than active nodes");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= EDGE_EMPTY)
      else $error("edge count beyond capacity");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("response word raised outside the emit step");
`endif

endmodule
`default_nettype wire

### design/dck_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dck_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 8
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
